/* design/ipmb_pkg.sv */
// ----------------------------------------------------------------------------
// ipmb_pkg
// Shared types and constants for the IP/MAC binding tracker.
// ----------------------------------------------------------------------------
package ipmb_pkg;

  localparam int TABLE_ENTRIES = 1024;

  localparam logic [2:0] EV_NONE       = 3'd0;
  localparam logic [2:0] EV_NEW        = 3'd1;
  localparam logic [2:0] EV_CHANGED    = 3'd2;
  localparam logic [2:0] EV_FLIPFLOP   = 3'd3;
  localparam logic [2:0] EV_REAPPEARED = 3'd4;
  localparam logic [2:0] EV_FULL       = 3'd5;

  localparam logic [31:0] REAPPEAR_RESET = 32'd3600;

  // input transaction
  typedef struct packed {
    logic        is_v6;
    logic [63:0] ip_high;
    logic [63:0] ip_low;
    logic [47:0] seen_mac;
    logic [31:0] now_seconds;
  } in_t;

  // result transaction
  typedef struct packed {
    logic [2:0]  event_res;
    logic [47:0] old_mac;
    logic [31:0] prior_seen;
  } out_t;

  // sighting travelling down the cell chain
  typedef struct packed {
    logic        vld;
    logic        done;     // claimed by a cell (hit or insert)
    logic        chk_time; // same-MAC hit, reappear test pending
    logic        is_v6;
    logic [63:0] ip_high;
    logic [63:0] ip_low;
    logic [47:0] mac;
    logic [31:0] now;
    logic [2:0]  ev;
    logic [47:0] old_mac;
    logic [31:0] old_seen;
  } tok_t;

endpackage

/* design/ip_mac_binding_tracker_core.sv */
// ----------------------------------------------------------------------------
// ip_mac_binding_tracker_core
// IP-to-MAC binding table built as a chain of slot cells.
//
//   channel | direction | handshake        | payload
//   in_     | input     | in_valid/in_stall  | ipmb_pkg::in_t
//   out_    | output    | out_valid/out_stall| ipmb_pkg::out_t
//   cfg_    | input     | cfg_valid/cfg_ready| idle threshold, 32 bit
//
// Each sighting walks the chain one cell per cycle when not stalled, then
// the result register; a new sighting can enter every cycle it is not stalled.
// The whole chain advances together; an output stall while a result is held freezes every stage.
// Reset empties all slots at once (one valid flop per cell); no clear pass.
// cfg_ready is always high.
// ----------------------------------------------------------------------------
module ip_mac_binding_tracker_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  ipmb_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output ipmb_pkg::out_t  out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [31:0]     cfg_data
);
  import ipmb_pkg::*;

  tok_t        tok [0:TABLE_ENTRIES];
  logic        evld [0:TABLE_ENTRIES-1];
  logic        adv;
  logic [31:0] reap_r;
  logic        ovld_r;
  out_t        out_r, out_nxt;
  tok_t        head;
  tok_t        tl;
  logic [31:0] elapsed;

  assign adv       = !ovld_r || !out_stall;
  assign in_stall  = !adv;
  assign cfg_ready = 1'b1;

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reap_r <= REAPPEAR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      reap_r <= cfg_data;
    end
  end

  // normalize the key into the chain head
  always_comb begin
    head          = '0;
    head.vld      = in_valid;
    head.is_v6    = in_data.is_v6;
    head.ip_high  = in_data.is_v6 ? in_data.ip_high : 64'd0;
    head.ip_low   = in_data.is_v6 ? in_data.ip_low : {32'd0, in_data.ip_low[31:0]};
    head.mac      = in_data.seen_mac;
    head.now      = in_data.now_seconds;
    head.ev       = EV_NONE;
  end

  assign tok[0] = head;

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    ipmb_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .tok_i     (tok[i]),
      .tok_o     (tok[i+1]),
      .entry_vld (evld[i])
    );
  end

  // result stage: full table and reappear test
  assign tl      = tok[TABLE_ENTRIES];
  assign elapsed = tl.now - tl.old_seen;

  always_comb begin
    out_nxt = '0;
    if (!tl.done) begin
      out_nxt.event_res = EV_FULL;
    end else if (tl.chk_time) begin
      if (elapsed >= reap_r) begin
        out_nxt.event_res  = EV_REAPPEARED;
        out_nxt.prior_seen = tl.old_seen;
      end
    end else begin
      out_nxt.event_res  = tl.ev;
      out_nxt.old_mac    = tl.old_mac;
      out_nxt.prior_seen = tl.old_seen;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r <= 1'b0;
    end else if (adv) begin
      ovld_r <= tl.vld;
    end
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = ovld_r;
  assign out_data  = out_r;

  a_ev_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.event_res <= EV_FULL)) else $error("bad event code");
  a_mac_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.event_res == EV_NONE || out_data.event_res == EV_NEW ||
     out_data.event_res == EV_FULL || out_data.event_res == EV_REAPPEARED))
    |-> (out_data.old_mac == 48'd0)) else $error("stray old MAC");
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.event_res == EV_FULL) |-> evld[TABLE_ENTRIES-1])
    else $error("full reported with free slot");

endmodule

/* design/ipmb_cell.sv */
// ----------------------------------------------------------------------------
// ipmb_cell
// One binding slot plus one pipeline stage of the lookup chain.
// ----------------------------------------------------------------------------
module ipmb_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  ipmb_pkg::tok_t tok_i,
  output ipmb_pkg::tok_t tok_o,
  output logic           entry_vld
);
  import ipmb_pkg::*;

  logic        vld_r, vld_nxt;
  logic        v6_r, v6_nxt;
  logic [63:0] hi_r, hi_nxt;
  logic [63:0] lo_r, lo_nxt;
  logic [47:0] mac_r, mac_nxt;
  logic [47:0] pmac_r, pmac_nxt;
  logic [31:0] seen_r, seen_nxt;
  tok_t        tok_r, tok_nxt;
  logic        hit;

  assign hit = vld_r && (v6_r == tok_i.is_v6) && (hi_r == tok_i.ip_high) &&
               (lo_r == tok_i.ip_low);

  // slot update and token hand-off
  always_comb begin
    vld_nxt  = vld_r;
    v6_nxt   = v6_r;
    hi_nxt   = hi_r;
    lo_nxt   = lo_r;
    mac_nxt  = mac_r;
    pmac_nxt = pmac_r;
    seen_nxt = seen_r;
    tok_nxt  = tok_i;
    if (tok_i.vld && !tok_i.done) begin
      if (hit) begin
        tok_nxt.done = 1'b1;
        seen_nxt     = tok_i.now;
        if (mac_r != tok_i.mac) begin
          tok_nxt.ev       = ((pmac_r != '0) && (pmac_r == tok_i.mac)) ?
                             EV_FLIPFLOP : EV_CHANGED;
          tok_nxt.old_mac  = mac_r;
          tok_nxt.old_seen = seen_r;
          pmac_nxt         = mac_r;
          mac_nxt          = tok_i.mac;
        end else begin
          tok_nxt.chk_time = 1'b1;
          tok_nxt.old_seen = seen_r;
        end
      end else if (!vld_r) begin
        // slots fill in order, so the first empty slot means a miss
        tok_nxt.done = 1'b1;
        tok_nxt.ev   = EV_NEW;
        vld_nxt      = 1'b1;
        v6_nxt       = tok_i.is_v6;
        hi_nxt       = tok_i.ip_high;
        lo_nxt       = tok_i.ip_low;
        mac_nxt      = tok_i.mac;
        pmac_nxt     = '0;
        seen_nxt     = tok_i.now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= 1'b0;
      tok_r.vld <= 1'b0;
    end else if (adv) begin
      vld_r     <= vld_nxt;
      tok_r.vld <= tok_nxt.vld;
    end
    if (adv) begin
      v6_r   <= v6_nxt;
      hi_r   <= hi_nxt;
      lo_r   <= lo_nxt;
      mac_r  <= mac_nxt;
      pmac_r <= pmac_nxt;
      seen_r <= seen_nxt;
      tok_r.done     <= tok_nxt.done;
      tok_r.chk_time <= tok_nxt.chk_time;
      tok_r.is_v6    <= tok_nxt.is_v6;
      tok_r.ip_high  <= tok_nxt.ip_high;
      tok_r.ip_low   <= tok_nxt.ip_low;
      tok_r.mac      <= tok_nxt.mac;
      tok_r.now      <= tok_nxt.now;
      tok_r.ev       <= tok_nxt.ev;
      tok_r.old_mac  <= tok_nxt.old_mac;
      tok_r.old_seen <= tok_nxt.old_seen;
    end
  end

  assign tok_o     = tok_r;
  assign entry_vld = vld_r;

  // a freshly inserted slot holds a cleared previous MAC
  a_ins_prev: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && !vld_r && tok_i.vld && !tok_i.done) |=> (vld_r && pmac_r == '0))
    else $error("insert left nonzero previous MAC");
  // a slot never empties once filled
  a_keep: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r |=> vld_r) else $error("slot lost");
  // a claimed token is never claimed again
  a_once: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && tok_i.vld && tok_i.done) |=> tok_r.done)
    else $error("token reclaimed");

endmodule

/* tb/sv/ipmb_checker.sv */
// ----------------------------------------------------------------------------
// ipmb_checker
// Watches the sighting, result and register channels of the binding tracker,
// keeps its own binding table to work out the event for every accepted
// sighting, and compares each result transaction with the oldest prediction.
// ----------------------------------------------------------------------------
module ipmb_checker
  import ipmb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_t         in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_t        out_data,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [47:0] mac;
    logic [47:0] earlier_mac;
    logic [31:0] seen_at;
  } binding_t;

  binding_t    bindings[logic [128:0]];
  int          bindings_used;
  logic [31:0] idle_limit_q;
  out_t        expected_events[$];

  // binding table lookup and update for one sighting
  function automatic out_t track_sighting(in_t s);
    logic [128:0] key;
    binding_t     b;
    out_t         r;
    r = '0;
    r.event_res = EV_NONE;
    key = s.is_v6 ? {1'b1, s.ip_high, s.ip_low} : {1'b0, 64'd0, 32'd0, s.ip_low[31:0]};
    if (!bindings.exists(key)) begin
      if (bindings_used < TABLE_ENTRIES) begin
        bindings[key] = '{mac: s.seen_mac, earlier_mac: 48'd0, seen_at: s.now_seconds};
        bindings_used++;
        r.event_res = EV_NEW;
      end else begin
        r.event_res = EV_FULL;
      end
    end else begin
      b = bindings[key];
      if (b.mac != s.seen_mac) begin
        r.old_mac = b.mac;
        r.prior_seen = b.seen_at;
        r.event_res = (b.earlier_mac != 0 && b.earlier_mac == s.seen_mac) ?
                      EV_FLIPFLOP : EV_CHANGED;
        b.earlier_mac = b.mac;
        b.mac = s.seen_mac;
      end else if (32'(s.now_seconds - b.seen_at) >= idle_limit_q) begin
        r.prior_seen = b.seen_at;
        r.event_res = EV_REAPPEARED;
      end
      b.seen_at = s.now_seconds;
      bindings[key] = b;
    end
    return r;
  endfunction

  // predict on accepted sightings, compare on accepted results
  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      bindings.delete();
      bindings_used = 0;
      idle_limit_q = REAPPEAR_RESET;
      expected_events.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) idle_limit_q = cfg_data;
      if (in_valid && !in_stall) expected_events.push_back(track_sighting(in_data));
      if (out_valid && !out_stall) begin
        if (expected_events.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result transaction: %p", out_data);
        end else begin
          want = expected_events.pop_front();
          if (want.event_res != out_data.event_res || want.old_mac != out_data.old_mac ||
              want.prior_seen != out_data.prior_seen) begin
            fail_count++;
            if (fail_count <= 10)
              $display("result error: expected ev=%0d mac=%h seen=%h, got ev=%0d mac=%h seen=%h",
                       want.event_res, want.old_mac, want.prior_seen, out_data.event_res,
                       out_data.old_mac, out_data.prior_seen);
          end
        end
      end
    end
    outstanding = expected_events.size();
  end

endmodule

/* tb/sv/tb_ip_mac_binding_tracker_core.sv */
// ----------------------------------------------------------------------------
// tb_ip_mac_binding_tracker_core
// Drives directed and random sightings into the binding tracker with random
// gaps and output stalls, steps the reappear threshold through its extremes
// between phases, and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_ip_mac_binding_tracker_core;
  timeunit 1ns;
  timeprecision 1ps;
  import ipmb_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int PHASE_ITEMS    = 360;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_t         in_data;
  logic        out_valid;
  logic        out_stall;
  out_t        out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;
  int          fail_count;
  int          outstanding;
  int          idle_cycles;
  bit          no_idle;

  typedef struct packed {
    logic        is_v6;
    logic [63:0] hi;
    logic [63:0] lo;
  } ip_key_t;

  ip_key_t     known_ips[$];
  logic [47:0] mac_pool[4];
  logic [31:0] clock_now;

  ip_mac_binding_tracker_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  ipmb_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .fail_count(fail_count), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // watchdog: cycles with no transaction on the sighting or result channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("ip_mac_binding_tracker_core: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: random stall before each result transaction
  initial begin
    int n;
    out_stall = 1'b1;
    @(posedge clk iff rst_n);
    forever begin
      n = no_idle ? 0 : $urandom_range(0, 9);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic send_sighting(in_t s);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if ($urandom_range(0, 99) == 0) no_idle = !no_idle;
  endtask

  task automatic sight(logic v6, logic [63:0] hi, logic [63:0] lo, logic [47:0] mac,
                       logic [31:0] t);
    in_t s;
    s = '{is_v6: v6, ip_high: hi, ip_low: lo, seen_mac: mac, now_seconds: t};
    send_sighting(s);
  endtask

  // register writes only once every outstanding result has been returned
  task automatic set_reappear(logic [31:0] v);
    in_valid <= 1'b0;
    wait (outstanding == 0);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // mostly new or revisited addresses drawn from a small MAC pool
  task automatic random_sighting();
    ip_key_t k;
    in_t     s;
    int      r;
    r = $urandom_range(0, 99);
    if (known_ips.size() == 0 || r < 62) begin
      k.is_v6 = 1'($urandom_range(0, 1));
      k.hi = {$urandom, $urandom};
      k.lo = {$urandom, $urandom};
      known_ips.push_back(k);
    end else begin
      k = known_ips[$urandom_range(0, known_ips.size() - 1)];
    end
    s.is_v6 = k.is_v6;
    s.ip_high = k.is_v6 ? k.hi : {$urandom, $urandom};
    s.ip_low = k.is_v6 ? k.lo : {$urandom, k.lo[31:0]};
    r = $urandom_range(0, 99);
    s.seen_mac = (r < 75) ? mac_pool[$urandom_range(0, 3)] :
                 (r < 78) ? 48'd0 : {$urandom, $urandom};
    if ($urandom_range(0, 19) == 0) clock_now = $urandom;
    else clock_now += 32'($urandom_range(0, 2500));
    s.now_seconds = clock_now;
    send_sighting(s);
  endtask

  initial begin
    logic [31:0] settings[5];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    idle_cycles = 0;
    no_idle = 1'b0;
    clock_now = 32'd1000;
    foreach (mac_pool[i]) mac_pool[i] = {$urandom, $urandom};
    settings = '{32'd0, 32'hFFFF_FFFF, 32'd1, $urandom, REAPPEAR_RESET};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: events, key folding, time wrap, zero MAC, extremes
    sight(1'b0, 64'd0, 64'h0000_0000_0A00_0001, 48'h0000_1111_2222, 32'd100);
    sight(1'b0, 64'd0, 64'h0000_0000_0A00_0001, 48'h0000_1111_2222, 32'd200);
    sight(1'b0, 64'd0, 64'h0000_0000_0A00_0001, 48'h0000_1111_2222, 32'd3799);
    sight(1'b0, 64'd0, 64'h0000_0000_0A00_0001, 48'h0000_1111_2222, 32'd7399);
    sight(1'b0, 64'd0, 64'h0000_0000_0A00_0001, 48'h0000_3333_4444, 32'd7400);
    sight(1'b0, 64'd0, 64'h0000_0000_0A00_0001, 48'h0000_1111_2222, 32'd7401);
    sight(1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_0A00_0001, 48'h0000_1111_2222,
          32'd7402);
    sight(1'b1, 64'd0, 64'h0000_0000_0A00_0001, 48'h0000_1111_2222, 32'd7403);
    sight(1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF,
          32'hFFFF_FF00);
    sight(1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF,
          32'h0000_0F00);
    sight(1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF,
          32'h0000_0F01);
    sight(1'b0, 64'd0, 64'h0000_0000_FFFF_FFFF, 48'd0, 32'hFFFF_FFFF);
    sight(1'b0, 64'd0, 64'h0000_0000_FFFF_FFFF, 48'h0000_0000_0001, 32'd0);
    sight(1'b0, 64'd0, 64'h0000_0000_FFFF_FFFF, 48'd0, 32'd1);
    sight(1'b0, 64'd0, 64'h0000_0000_FFFF_FFFF, 48'h0000_0000_0001, 32'd2);
    sight(1'b0, 64'd0, 64'h0000_0000_0000_0000, 48'h8000_0000_0000, 32'd0);
    sight(1'b0, 64'd0, 64'h0000_0000_0000_0000, 48'h8000_0000_0000, 32'hFFFF_FFFF);

    // random phases across threshold settings; table fills along the way
    for (int p = 0; p < 5; p++) begin
      set_reappear(settings[p]);
      for (int i = 0; i < PHASE_ITEMS; i++) random_sighting();
    end
    in_valid <= 1'b0;

    wait (outstanding == 0);
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("ip_mac_binding_tracker_core: match");
    end else begin
      $display("ip_mac_binding_tracker_core: mismatch");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/ipmb_pkg.sv
design/ipmb_cell.sv
design/ip_mac_binding_tracker_core.sv
tb/sv/ipmb_checker.sv
tb/sv/tb_ip_mac_binding_tracker_core.sv
